// ----- rtl/small_language_lexer_macros.svh -----
// assertion helpers for the lexer checker
`ifndef SMALL_LANGUAGE_LEXER_MACROS_SVH
`define SMALL_LANGUAGE_LEXER_MACROS_SVH

// property checked outside reset
`define SLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define SLL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sll_pkg.sv -----
// ----------------------------------------------------------------------------
// sll_pkg
// Token kinds, scan modes, keyword table and shared types of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sll_pkg;

  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_PLUS   = 5'd1;
  localparam logic [4:0] KIND_MINUS  = 5'd2;
  localparam logic [4:0] KIND_STAR   = 5'd3;
  localparam logic [4:0] KIND_SLASH  = 5'd4;
  localparam logic [4:0] KIND_LPAREN = 5'd5;
  localparam logic [4:0] KIND_RPAREN = 5'd6;
  localparam logic [4:0] KIND_NOTEQ  = 5'd7;
  localparam logic [4:0] KIND_ASSIGN = 5'd8;
  localparam logic [4:0] KIND_EQEQ   = 5'd9;
  localparam logic [4:0] KIND_COLON  = 5'd10;
  localparam logic [4:0] KIND_SEMI   = 5'd11;
  localparam logic [4:0] KIND_COMMA  = 5'd12;
  localparam logic [4:0] KIND_LBRACE = 5'd13;
  localparam logic [4:0] KIND_RBRACE = 5'd14;
  localparam logic [4:0] KIND_INTLIT = 5'd15;
  localparam logic [4:0] KIND_DECLIT = 5'd16;
  localparam logic [4:0] KIND_KW0    = 5'd17;
  localparam logic [4:0] KIND_IDENT  = 5'd25;
  localparam logic [4:0] KIND_ERROR  = 5'd26;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BANG,
    MODE_EQ,
    MODE_INT,
    MODE_FRAC,
    MODE_WORD
  } mode_t;

  // keywords: int double void let set fun return if
  localparam logic [7:0] KW_TEXT [8][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd6, 3'd4, 3'd3, 3'd3, 3'd3, 3'd6, 3'd2};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } emit_t;

  // keep keywords whose next character matches
  function automatic logic [7:0] kw_narrow(logic [7:0] cand, logic [15:0] idx,
                                           logic [7:0] c);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (cand[i] && (idx < {13'd0, KW_LEN[i]}) && (KW_TEXT[i][idx[2:0]] == c)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] word_kind(logic [7:0] cand, logic [15:0] len);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i] && (len == {13'd0, KW_LEN[i]})) begin
        k = KIND_KW0 + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sll_scan.sv -----
// ----------------------------------------------------------------------------
// sll_scan
// Scanner state and per-byte token decision: up to two tokens per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_scan #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    text_byte,
  output sll_pkg::emit_t     emit
);
  import sll_pkg::*;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] char_position, position_next;
  logic [POSITION_BITS-1:0] pending_start, start_next;
  logic [15:0]              pending_length, length_next;
  logic                     fraction_seen, fraction_next;
  logic [7:0]               candidates, candidates_next;

  logic        pv, rv, rescan;
  logic [4:0]  pk, rk;
  logic [15:0] pl, grown;
  logic [7:0]  c;
  tok_t        ptok, rtok;

  function automatic logic [4:0] op_kind(logic [7:0] ch);
    logic [4:0] k;
    case (ch)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ":":     k = KIND_COLON;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  always_comb begin
    c               = text_byte;
    grown           = (pending_length == LEN_MAX) ? LEN_MAX : pending_length + 16'd1;
    mode_next       = mode;
    start_next      = pending_start;
    length_next     = pending_length;
    fraction_next   = fraction_seen;
    candidates_next = candidates;
    position_next   = char_position + POSITION_BITS'(1);
    pv              = 1'b0;
    pk              = KIND_END;
    pl              = pending_length;
    rescan          = 1'b0;
    rv              = 1'b0;
    rk              = KIND_END;

    case (mode)
      MODE_BANG: begin
        pv = 1'b1;
        pl = 16'd2;
        if (c == "=") begin
          pk = KIND_NOTEQ;
        end else begin
          pk     = KIND_ERROR;
          rescan = (c == 8'h00);
        end
        mode_next = MODE_IDLE;
      end
      MODE_EQ: begin
        pv = 1'b1;
        if (c == "=") begin
          pk = KIND_EQEQ;
          pl = 16'd2;
        end else begin
          pk     = KIND_ASSIGN;
          pl     = 16'd1;
          rescan = 1'b1;
        end
        mode_next = MODE_IDLE;
      end
      MODE_INT: begin
        if (c inside {["0":"9"]}) begin
          length_next = grown;
        end else if (c == ".") begin
          length_next   = grown;
          fraction_next = 1'b0;
          mode_next     = MODE_FRAC;
        end else begin
          pv     = 1'b1;
          pk     = KIND_INTLIT;
          rescan = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (c inside {["0":"9"]}) begin
          length_next   = grown;
          fraction_next = 1'b1;
        end else begin
          pv     = 1'b1;
          pk     = fraction_seen ? KIND_DECLIT : KIND_ERROR;
          rescan = 1'b1;
        end
      end
      MODE_WORD: begin
        if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) begin
          candidates_next = kw_narrow(candidates, pending_length, c);
          length_next     = grown;
        end else begin
          pv     = 1'b1;
          pk     = word_kind(candidates, pending_length);
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (rescan) begin
      mode_next = MODE_IDLE;
      if (c == 8'h00) begin
        rv = 1'b1;
        rk = KIND_END;
      end else if (op_kind(c) != KIND_END) begin
        rv = 1'b1;
        rk = op_kind(c);
      end else if (c inside {" ", [8'd9:8'd13]}) begin
        rv = 1'b0;
      end else if (c == "!") begin
        mode_next   = MODE_BANG;
        start_next  = char_position;
        length_next = 16'd1;
      end else if (c == "=") begin
        mode_next   = MODE_EQ;
        start_next  = char_position;
        length_next = 16'd1;
      end else if (c inside {["0":"9"]}) begin
        mode_next   = MODE_INT;
        start_next  = char_position;
        length_next = 16'd1;
      end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
        mode_next       = MODE_WORD;
        start_next      = char_position;
        length_next     = 16'd1;
        candidates_next = kw_narrow(8'hFF, 16'd0, c);
      end else begin
        rv = 1'b1;
        rk = KIND_ERROR;
      end
    end

    // end of text clears everything
    if (c == 8'h00) begin
      mode_next       = MODE_IDLE;
      position_next   = '0;
      start_next      = '0;
      length_next     = '0;
      fraction_next   = 1'b0;
      candidates_next = '0;
    end

    ptok.kind   = pk;
    ptok.start  = 16'(pending_start);
    ptok.length = pl;
    ptok.last   = !rv;
    rtok.kind   = rk;
    rtok.start  = 16'(char_position);
    rtok.length = 16'd1;
    rtok.last   = 1'b1;

    emit.count  = {1'b0, pv} + {1'b0, rv};
    emit.first  = pv ? ptok : rtok;
    emit.second = rtok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      char_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      fraction_seen  <= 1'b0;
      candidates     <= '0;
    end else if (take) begin
      mode           <= mode_next;
      char_position  <= position_next;
      pending_start  <= start_next;
      pending_length <= length_next;
      fraction_seen  <= fraction_next;
      candidates     <= candidates_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/small_language_lexer.sv -----
// ----------------------------------------------------------------------------
// small_language_lexer
// Streaming tokenizer: source bytes in, tokens with kind, start and length out.
// ----------------------------------------------------------------------------
// Usage:
//   text channel: one source byte per request on text_byte; a zero byte ends
//   the text, flushes any pending token, sends an end token and restarts the
//   position count at zero.
//   token channel: one token per request (token_kind, token_start,
//   token_length); last_of_run marks the final token caused by one byte.
// Timing:
//   a byte taken into an empty queue shows its first token on the next cycle.
//   one byte per cycle is taken while text_stall is low; a byte that
//   closes a pending token and is itself a one-byte token, a stray byte or
//   the end of text yields two tokens (after a pending "!" only the end of
//   text does), which leave one at a time from a four-entry token queue.
//   text_stall rises while fewer than two queue entries are free.
// Reset: the queue is emptied and the scanner goes idle at position zero.
// A stall on the token side holds the head token steady; bytes keep being
// taken until three queue entries are in use.
// ----------------------------------------------------------------------------
`default_nettype none

module small_language_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  text_byte,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [4:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_of_run
);
  import sll_pkg::*;

  emit_t      emit;
  tok_t       queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       push, pop;
  logic [1:0] n_push;
  tok_t       head;

  assign push   = text_valid && !text_stall;
  assign pop    = token_valid && !token_stall;
  assign n_push = push ? emit.count : 2'd0;

  sll_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (push),
    .text_byte (text_byte),
    .emit      (emit)
  );

  assign count_next = count + {1'b0, n_push} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= emit.first;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + 2'd1] <= emit.second;
    end
  end

  assign head         = queue[rd_ptr];
  assign text_stall   = (count > 3'd2);
  assign token_valid  = (count != 3'd0);
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

`default_nettype wire

// ----- rtl/sll_checker.sv -----
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "small_language_lexer_macros.svh"

module sll_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        text_stall,
  input wire logic        token_valid,
  input wire logic        token_stall,
  input wire logic [4:0]  token_kind,
  input wire logic [15:0] token_start,
  input wire logic [15:0] token_length,
  input wire logic        last_of_run
);
  import sll_pkg::*;

  logic [37:0] token_bus;
  logic        single_kind;
  logic        pair_kind;

  assign token_bus   = {token_kind, token_start, token_length, last_of_run};
  assign single_kind = token_kind inside {KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH,
                                          KIND_LPAREN, KIND_RPAREN, KIND_ASSIGN, KIND_COLON,
                                          KIND_SEMI, KIND_COMMA, KIND_LBRACE, KIND_RBRACE};
  assign pair_kind   = token_kind inside {KIND_NOTEQ, KIND_EQEQ};

  // held token stays put
  `SLL_ASSERT(a_hold, token_valid && token_stall |=> token_valid && $stable(token_bus), "stalled token changed")

  // queue empty and input open right after reset
  `SLL_ASSERT_RST(a_reset_empty, rst |=> !token_valid && !text_stall, "queue not empty after reset")

  // end token is one byte and closes its run
  `SLL_ASSERT(a_end_token, token_valid && token_kind == KIND_END |-> token_length == 16'd1 && last_of_run, "bad end token")

  // single-character tokens are one byte long
  `SLL_ASSERT(a_single_len, token_valid && single_kind |-> token_length == 16'd1, "single-character token too long")

  // two-character operators
  `SLL_ASSERT(a_pair_len, token_valid && pair_kind |-> token_length == 16'd2, "bad operator length")

endmodule

bind small_language_lexer sll_checker u_sll_checker (.*);

`default_nettype wire

// ----- bench/small_language_lexer_tb.sv -----
// ----------------------------------------------------------------------------
// small_language_lexer_tb
// Self-checking bench for the streaming lexer. Source bytes go in over the
// text channel and a behavioral scanner inside the bench builds the expected
// token stream, which is compared field by field with the token channel. A
// short directed table comes first, then random text in four idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module small_language_lexer_tb;
  import sll_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 263;
  localparam int DRAIN_CYCLES     = 20;

  typedef struct packed {
    logic [7:0]  ch;
    logic        typed;
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
  } directed_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       typed;
    tok_t       tok;
  } text_item_t;

  // typed rows carry the one token they must cause; others use the scanner's
  localparam directed_row_t DIRECTED [26] = '{
    '{"+",   1'b1, KIND_PLUS,   16'd0,  16'd1},
    '{"}",   1'b1, KIND_RBRACE, 16'd1,  16'd1},
    '{8'hFF, 1'b1, KIND_ERROR,  16'd2,  16'd1},
    '{8'h80, 1'b1, KIND_ERROR,  16'd3,  16'd1},
    '{"!",   1'b0, KIND_END,    16'd0,  16'd0},
    '{" ",   1'b1, KIND_ERROR,  16'd4,  16'd2},
    '{"!",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"=",   1'b1, KIND_NOTEQ,  16'd6,  16'd2},
    '{"=",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"=",   1'b1, KIND_EQEQ,   16'd8,  16'd2},
    '{"=",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"(",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"7",   1'b0, KIND_END,    16'd0,  16'd0},
    '{".",   1'b0, KIND_END,    16'd0,  16'd0},
    '{";",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"4",   1'b0, KIND_END,    16'd0,  16'd0},
    '{".",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"2",   1'b0, KIND_END,    16'd0,  16'd0},
    '{8'h0D, 1'b0, KIND_END,    16'd0,  16'd0},
    '{"i",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"f",   1'b0, KIND_END,    16'd0,  16'd0},
    '{",",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"x",   1'b0, KIND_END,    16'd0,  16'd0},
    '{"!",   1'b0, KIND_END,    16'd0,  16'd0},
    '{8'h00, 1'b0, KIND_END,    16'd0,  16'd0},
    '{8'h00, 1'b1, KIND_END,    16'd0,  16'd1}
  };

  string keyword_text [8] = '{"int", "double", "void", "let", "set", "fun", "return", "if"};
  string operator_chars = "+-*/():;,{}";
  // letters and underscore first, digits last
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  // scanner state
  mode_t       lex_mode;
  logic [15:0] lex_pos;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic        frac_seen;
  logic [7:0]  kw_live;
  tok_t        step_toks [$];

  tok_t        token_q [$];
  text_item_t  stim_q [$];
  text_item_t  cur_item;

  int pushed_count = 0;
  int accepted_count = 0;
  int random_count = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic long_hold_en = 1'b0;
  logic holding = 1'b0;

  small_language_lexer u_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always #6 clk = ~clk;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [15:0] grow_len(logic [15:0] n);
    return (n == LEN_MAX) ? LEN_MAX : n + 16'd1;
  endfunction

  function automatic logic [7:0] keyword_filter(logic [7:0] live, logic [15:0] idx,
                                                logic [7:0] c);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (live[i] && idx < keyword_text[i].len() && keyword_text[i][idx] == c) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] word_token_kind(logic [7:0] live, logic [15:0] n);
    for (int i = 0; i < 8; i++) begin
      if (live[i] && n == keyword_text[i].len()) begin
        return KIND_KW0 + 5'(i);
      end
    end
    return KIND_IDENT;
  endfunction

  task automatic lexer_state_clear();
    lex_mode  = MODE_IDLE;
    lex_pos   = '0;
    tok_start = '0;
    tok_len   = '0;
    frac_seen = 1'b0;
    kw_live   = '0;
  endtask

  task automatic add_token(logic [4:0] k, logic [15:0] s, logic [15:0] n);
    step_toks.push_back('{kind: k, start: s, length: n, last: 1'b0});
  endtask

  task automatic open_token(mode_t m, logic [15:0] p);
    lex_mode  = m;
    tok_start = p;
    tok_len   = 16'd1;
  endtask

  // byte seen with nothing pending
  task automatic scan_fresh(logic [7:0] c, logic [15:0] p);
    logic [4:0] op_kind;
    logic       is_op;
    is_op   = 1'b1;
    op_kind = KIND_END;
    case (c)
      "+": op_kind = KIND_PLUS;
      "-": op_kind = KIND_MINUS;
      "*": op_kind = KIND_STAR;
      "/": op_kind = KIND_SLASH;
      "(": op_kind = KIND_LPAREN;
      ")": op_kind = KIND_RPAREN;
      ":": op_kind = KIND_COLON;
      ";": op_kind = KIND_SEMI;
      ",": op_kind = KIND_COMMA;
      "{": op_kind = KIND_LBRACE;
      "}": op_kind = KIND_RBRACE;
      default: is_op = 1'b0;
    endcase
    lex_mode = MODE_IDLE;
    if (is_op) begin
      add_token(op_kind, p, 16'd1);
    end else if (!is_space(c)) begin
      if (c == "!") begin
        open_token(MODE_BANG, p);
      end else if (c == "=") begin
        open_token(MODE_EQ, p);
      end else if (is_digit(c)) begin
        open_token(MODE_INT, p);
      end else if (is_alpha(c) || c == "_") begin
        open_token(MODE_WORD, p);
        kw_live = keyword_filter(8'hFF, 16'd0, c);
      end else begin
        add_token(KIND_ERROR, p, 16'd1);
      end
    end
  endtask

  // tokens caused by one accepted byte, left in step_toks
  task automatic lex_step(logic [7:0] c);
    logic [15:0] p;
    logic        rescan;
    tok_t        tail;
    p      = lex_pos;
    rescan = 1'b0;
    step_toks.delete();
    case (lex_mode)
      MODE_BANG: begin
        if (c == "=") begin
          add_token(KIND_NOTEQ, tok_start, 16'd2);
        end else begin
          add_token(KIND_ERROR, tok_start, 16'd2);
          rescan = (c == 8'h00);
        end
        lex_mode = MODE_IDLE;
      end
      MODE_EQ: begin
        if (c == "=") begin
          add_token(KIND_EQEQ, tok_start, 16'd2);
        end else begin
          add_token(KIND_ASSIGN, tok_start, 16'd1);
          rescan = 1'b1;
        end
        lex_mode = MODE_IDLE;
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          tok_len = grow_len(tok_len);
        end else if (c == ".") begin
          tok_len   = grow_len(tok_len);
          frac_seen = 1'b0;
          lex_mode  = MODE_FRAC;
        end else begin
          add_token(KIND_INTLIT, tok_start, tok_len);
          rescan = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (is_digit(c)) begin
          tok_len   = grow_len(tok_len);
          frac_seen = 1'b1;
        end else begin
          add_token(frac_seen ? KIND_DECLIT : KIND_ERROR, tok_start, tok_len);
          rescan = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          kw_live = keyword_filter(kw_live, tok_len, c);
          tok_len = grow_len(tok_len);
        end else begin
          add_token(word_token_kind(kw_live, tok_len), tok_start, tok_len);
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      lex_mode = MODE_IDLE;
      if (c == 8'h00) begin
        add_token(KIND_END, p, 16'd1);
      end else begin
        scan_fresh(c, p);
      end
    end
    if (c == 8'h00) begin
      lexer_state_clear();
    end else begin
      lex_pos = p + 16'd1;
    end
    if (step_toks.size() != 0) begin
      tail      = step_toks.pop_back();
      tail.last = 1'b1;
      step_toks.push_back(tail);
    end
  endtask

  task automatic push_byte(logic [7:0] c);
    text_item_t item;
    item.ch    = c;
    item.typed = 1'b0;
    item.tok   = '0;
    stim_q.push_back(item);
    pushed_count++;
    random_count++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] random_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] random_space();
    int n;
    n = $urandom_range(5);
    return (n == 5) ? 8'h20 : 8'(9 + n);
  endfunction

  // mostly well-formed tokens, with stray bytes and broken ones mixed in
  task automatic queue_random_token();
    int    pick;
    int    n;
    string kw;
    pick = $urandom_range(99);
    if (pick < 10) begin
      push_byte(8'($urandom_range(255)));
    end else if (pick < 13) begin
      push_byte(8'h00);
    end else if (pick < 25) begin
      push_byte(operator_chars[$urandom_range(operator_chars.len() - 1)]);
    end else if (pick < 33) begin
      case ($urandom_range(3))
        0: push_text("!=");
        1: push_text("==");
        2: push_byte("=");
        default: begin
          push_byte("!");
          push_byte(8'($urandom_range(255)));
        end
      endcase
    end else if (pick < 45) begin
      n = $urandom_range(5, 1);
      repeat (n) push_byte(random_digit());
    end else if (pick < 55) begin
      n = $urandom_range(3, 1);
      repeat (n) push_byte(random_digit());
      push_byte(".");
      n = $urandom_range(3);
      repeat (n) push_byte(random_digit());
    end else if (pick < 70) begin
      push_text(keyword_text[$urandom_range(7)]);
    end else if (pick < 80) begin
      // near misses of a keyword: cut short or one character too many
      kw = keyword_text[$urandom_range(7)];
      if ($urandom_range(1) == 0) begin
        push_text(kw.substr(0, kw.len() - 2));
      end else begin
        push_text(kw);
        push_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
      end
    end else if (pick < 90) begin
      push_byte(word_chars[$urandom_range(52)]);
      n = $urandom_range(7);
      repeat (n) push_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) push_byte(random_space());
    end
    if ($urandom_range(1) == 0) begin
      push_byte(random_space());
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || token_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want != got) begin
      $display("%0t: token %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // text side: offer the next byte, run the scanner on each accepted one
  always @(posedge clk) begin : text_driver
    if (rst) begin
      text_valid <= 1'b0;
      lexer_state_clear();
    end else begin
      if (text_valid && !text_stall) begin
        lex_step(cur_item.ch);
        if (cur_item.typed) begin
          token_q.push_back(cur_item.tok);
        end else begin
          foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        end
        accepted_count++;
      end
      if (!text_valid || !text_stall) begin
        if (stim_q.size() != 0 &&
            !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
          cur_item = stim_q.pop_front();
          text_byte  <= cur_item.ch;
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // token side: compare each accepted token with the oldest one expected
  always @(posedge clk) begin : token_monitor
    tok_t want;
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual kind %0d start %0d len %0d",
                   $time, token_kind, token_start, token_length);
          errors++;
        end else begin
          want = token_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(token_kind));
          check_field("start", want.start, token_start);
          check_field("length", want.length, token_length);
          check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        end
      end
      token_stall <= holding || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off so the token queue fills and text_stall rises
  initial begin : receiver_holdoff
    wait (long_hold_en);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL small_language_lexer");
    $finish;
  end

  initial begin : run_control
    text_item_t item;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      item.ch    = DIRECTED[i].ch;
      item.typed = DIRECTED[i].typed;
      item.tok   = '{kind: DIRECTED[i].kind, start: DIRECTED[i].start,
                     length: DIRECTED[i].length, last: 1'b1};
      stim_q.push_back(item);
      pushed_count++;
    end
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_hold_en  = 1'b1;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 72;
        end
        default: begin
          send_idle_pct = 24;
          recv_idle_pct = 24;
        end
      endcase
      random_count = 0;
      while (random_count < RANDOM_PER_PHASE) queue_random_token();
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS small_language_lexer");
    end else begin
      $display("FAIL small_language_lexer");
    end
    $finish;
  end

endmodule

`default_nettype wire
